// ----- src/gsc_pkg.sv -----
// Package for the Gray-Scott cell engine: fixed-point constants, action and
// register codes, the configuration bundle and the divide-by-five constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int CELL_W    = 2 * DATA_W;

  localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_BITS);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_SWAP  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] CFG_DIFF_A = 2'd0;
  localparam logic [1:0] CFG_DIFF_B = 2'd1;
  localparam logic [1:0] CFG_FEED   = 2'd2;
  localparam logic [1:0] CFG_KILL   = 2'd3;

  localparam logic [DATA_W-1:0] RST_DIFF_A = 16'd32768;
  localparam logic [DATA_W-1:0] RST_DIFF_B = 16'd16384;
  localparam logic [DATA_W-1:0] RST_FEED   = 16'd1802;
  localparam logic [DATA_W-1:0] RST_KILL   = 16'd2032;

  // floor(u / 5) ~ (u * DIV5_MUL) >> DIV5_SHIFT, low by at most one for u < 2^20
  localparam int          DIV5_SHIFT = 21;
  localparam logic [18:0] DIV5_MUL   = 19'((1 << 21) / 5);

  typedef struct packed {
    logic [DATA_W-1:0] diff_a;
    logic [DATA_W-1:0] diff_b;
    logic [DATA_W-1:0] feed;
    logic [DATA_W-1:0] kill;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/gsc_front.sv -----
// Front end: accepts input beats, wraps coordinates onto the grid and drops
// unused actions before queueing. Depends on gsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsc_front #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  wire logic                        enable,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [7:0]                  x_pos,
  input  wire logic [7:0]                  y_pos,
  input  wire logic [gsc_pkg::DATA_W-1:0]  conc_a,
  input  wire logic [gsc_pkg::DATA_W-1:0]  conc_b,
  input  wire logic                        q_ready,
  output logic                             q_valid,
  output logic [2+$clog2(GRID_HEIGHT)+$clog2(GRID_WIDTH)+2*gsc_pkg::DATA_W-1:0] q_data
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);

  logic [XW-1:0] x_tab [256];
  logic [YW-1:0] y_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign x_tab[i] = XW'(i % GRID_WIDTH);
    assign y_tab[i] = YW'(i % GRID_HEIGHT);
  end

  assign in_ready = enable & q_ready;
  assign q_valid  = in_valid & in_ready & (action != gsc_pkg::ACT_NOP);
  assign q_data   = {action, y_tab[y_pos], x_tab[x_pos], conc_a, conc_b};

endmodule

`default_nettype wire

// ----- src/gsc_queue.sv -----
// Two-entry queue between front and back end.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps
`default_nettype none

module gsc_queue #(
  parameter int WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/gsc_back.sv -----
// Back end: both cell banks, the clearing sweep, the stencil sequencer with
// its shared multiplier, and the result register. Depends on gsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsc_back #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gsc_pkg::cfg_t               cfg,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [2+$clog2(GRID_HEIGHT)+$clog2(GRID_WIDTH)+2*gsc_pkg::DATA_W-1:0] q_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [gsc_pkg::DATA_W-1:0]       new_a,
  output logic [gsc_pkg::DATA_W-1:0]       new_b,
  output logic [7:0]                       gray_level,
  output logic                             clearing
);

  localparam int DW    = gsc_pkg::DATA_W;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int CELLS = 1 << AW;
  localparam int QW    = 2 + YW + XW + 2 * DW;

  typedef enum logic [13:0] {
    ST_CLEAR = 14'h0001,
    ST_IDLE  = 14'h0002,
    ST_READ  = 14'h0004,
    ST_MDA   = 14'h0008,
    ST_MDB   = 14'h0010,
    ST_MAB   = 14'h0020,
    ST_MABB  = 14'h0040,
    ST_MFA   = 14'h0080,
    ST_MKB   = 14'h0100,
    ST_DAM   = 14'h0200,
    ST_DAC   = 14'h0400,
    ST_DBC   = 14'h0800,
    ST_SUM   = 14'h1000,
    ST_OUT   = 14'h2000
  } state_t;

  state_t state;

  logic [gsc_pkg::CELL_W-1:0] bank0 [CELLS];
  logic [gsc_pkg::CELL_W-1:0] bank1 [CELLS];
  logic [gsc_pkg::CELL_W-1:0] rd0;
  logic [gsc_pkg::CELL_W-1:0] rd1;
  logic [gsc_pkg::CELL_W-1:0] rd_cell;
  logic [gsc_pkg::CELL_W-1:0] wr_data;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       wr0;
  logic                       wr1;
  logic [AW-1:0]              clr_cnt;
  logic                       cur_bank;

  logic [1:0]    q_act;
  logic [YW-1:0] q_y;
  logic [XW-1:0] q_x;
  logic [DW-1:0] q_a;
  logic [DW-1:0] q_b;

  logic [XW-1:0] jx;
  logic [YW-1:0] jy;
  logic [XW-1:0] xm;
  logic [XW-1:0] xp;
  logic [YW-1:0] ym;
  logic [YW-1:0] yp;
  logic [3:0]    rd_cnt;
  logic [3:0]    prev;

  logic signed [22:0] la;
  logic signed [22:0] lb;
  logic signed [22:0] ext_a;
  logic signed [22:0] ext_b;
  logic signed [22:0] term_a;
  logic signed [22:0] term_b;
  logic [DW-1:0]      ca;
  logic [DW-1:0]      cb;

  logic signed [23:0] mul_x;
  logic signed [19:0] mul_y;
  logic signed [43:0] prod;

  logic signed [20:0] t_lap;
  logic signed [20:0] t_neg;
  logic [19:0]        ua;
  logic [19:0]        ub;
  logic               neg_a;
  logic               neg_b;
  logic [18:0]        abb;
  logic signed [17:0] fa;
  logic [18:0]        kb;
  logic signed [18:0] da;
  logic signed [18:0] db;
  logic [17:0]        q_est;
  logic [17:0]        q_a_fix;
  logic [17:0]        q_b_fix;
  logic [16:0]        kf_sum;

  logic signed [23:0] na_raw;
  logic signed [23:0] nb_raw;
  logic signed [23:0] s_ca;
  logic signed [23:0] s_cb;
  logic signed [23:0] s_da;
  logic signed [23:0] s_db;
  logic signed [23:0] s_abb;
  logic signed [23:0] s_fa;
  logic signed [23:0] s_kb;
  logic [DW-1:0]      na;
  logic [DW-1:0]      nb;
  logic [DW-1:0]      na_c;
  logic [DW-1:0]      nb_c;
  logic [DW-1:0]      g_diff;
  logic [23:0]        g_mul;
  logic [8:0]         g_raw;
  logic [7:0]         gray;
  logic               out_fire;

  function automatic logic [17:0] div5_fix(input logic [19:0] u, input logic [17:0] q);
    logic [19:0] r;
    r = u - ({q, 2'b00} + {2'b00, q});
    return (r >= 20'd5) ? q + 18'd1 : q;
  endfunction

  function automatic logic [DW-1:0] clamp_unit(input logic signed [23:0] v);
    logic [DW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({8'b0, gsc_pkg::Q_ONE})) begin
      res = gsc_pkg::Q_ONE;
    end else begin
      res = v[DW-1:0];
    end
    return res;
  endfunction

  assign q_act = q_data[QW-1 -: 2];
  assign q_y   = q_data[2*DW+XW +: YW];
  assign q_x   = q_data[2*DW +: XW];
  assign q_a   = q_data[DW +: DW];
  assign q_b   = q_data[0 +: DW];

  assign q_ready  = (state == ST_IDLE);
  assign clearing = (state == ST_CLEAR);
  assign out_fire = (state == ST_OUT) && (!out_valid || out_ready);

  assign xm = (jx == '0) ? XW'(GRID_WIDTH - 1) : jx - XW'(1);
  assign xp = (jx == XW'(GRID_WIDTH - 1)) ? '0 : jx + XW'(1);
  assign ym = (jy == '0) ? YW'(GRID_HEIGHT - 1) : jy - YW'(1);
  assign yp = (jy == YW'(GRID_HEIGHT - 1)) ? '0 : jy + YW'(1);

  always_comb begin
    unique case (rd_cnt)
      4'd0:    rd_addr = {ym, xm};
      4'd1:    rd_addr = {ym, jx};
      4'd2:    rd_addr = {ym, xp};
      4'd3:    rd_addr = {jy, xm};
      4'd4:    rd_addr = {jy, jx};
      4'd5:    rd_addr = {jy, xp};
      4'd6:    rd_addr = {yp, xm};
      4'd7:    rd_addr = {yp, jx};
      default: rd_addr = {yp, xp};
    endcase
  end

  assign rd_cell = cur_bank ? rd1 : rd0;
  assign prev    = rd_cnt - 4'd1;
  assign ext_a   = $signed({7'b0, rd_cell[2*DW-1:DW]});
  assign ext_b   = $signed({7'b0, rd_cell[DW-1:0]});

  // centre -20, edges 4, corners 1
  always_comb begin
    unique case (prev)
      4'd4: begin
        term_a = -((ext_a <<< 4) + (ext_a <<< 2));
        term_b = -((ext_b <<< 4) + (ext_b <<< 2));
      end
      4'd1, 4'd3, 4'd5, 4'd7: begin
        term_a = ext_a <<< 2;
        term_b = ext_b <<< 2;
      end
      default: begin
        term_a = ext_a;
        term_b = ext_b;
      end
    endcase
  end

  assign kf_sum = {1'b0, cfg.kill} + {1'b0, cfg.feed};

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      ST_MDA: begin
        mul_x = 24'(la);
        mul_y = $signed({4'b0, cfg.diff_a});
      end
      ST_MDB: begin
        mul_x = 24'(lb);
        mul_y = $signed({4'b0, cfg.diff_b});
      end
      ST_MAB: begin
        mul_x = $signed({8'b0, ca});
        mul_y = $signed({4'b0, cb});
      end
      ST_MABB: begin
        mul_x = $signed({6'b0, prod[32:15]});
        mul_y = $signed({4'b0, cb});
      end
      ST_MFA: begin
        mul_x = $signed({8'b0, cfg.feed});
        mul_y = $signed(20'd32768) - $signed({4'b0, ca});
      end
      ST_MKB: begin
        mul_x = $signed({7'b0, kf_sum});
        mul_y = $signed({4'b0, cb});
      end
      ST_DAM: begin
        mul_x = $signed({4'b0, ua});
        mul_y = $signed({1'b0, gsc_pkg::DIV5_MUL});
      end
      ST_DAC: begin
        mul_x = $signed({4'b0, ub});
        mul_y = $signed({1'b0, gsc_pkg::DIV5_MUL});
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign t_lap   = $signed(prod[37:17]);
  assign t_neg   = -t_lap + 21'sd4;
  assign q_est   = prod[38:21];
  assign q_a_fix = div5_fix(ua, q_est);
  assign q_b_fix = div5_fix(ub, q_est);

  assign s_ca  = $signed({8'b0, ca});
  assign s_cb  = $signed({8'b0, cb});
  assign s_da  = 24'(da);
  assign s_db  = 24'(db);
  assign s_abb = $signed({5'b0, abb});
  assign s_fa  = 24'(fa);
  assign s_kb  = $signed({5'b0, kb});
  assign na_raw = s_ca + s_da - s_abb + s_fa;
  assign nb_raw = s_cb + s_db + s_abb - s_kb;
  assign na_c   = clamp_unit(na_raw);
  assign nb_c   = clamp_unit(nb_raw);

  assign g_diff = na - nb;
  assign g_mul  = ({8'b0, g_diff} << 8) - {8'b0, g_diff};
  assign g_raw  = g_mul[23:15];
  assign gray   = (na <= nb) ? 8'd0 : ((g_raw > 9'd255) ? 8'd255 : g_raw[7:0]);

  always_comb begin
    wr0     = 1'b0;
    wr1     = 1'b0;
    wr_addr = {q_y, q_x};
    wr_data = {q_a, q_b};
    if (state == ST_CLEAR) begin
      wr0     = 1'b1;
      wr1     = 1'b1;
      wr_addr = clr_cnt;
      wr_data = {gsc_pkg::Q_ONE, {DW{1'b0}}};
    end else if (state == ST_IDLE && q_valid && q_act == gsc_pkg::ACT_WRITE) begin
      wr0 = ~cur_bank;
      wr1 = cur_bank;
    end else if (out_fire) begin
      wr0     = cur_bank;
      wr1     = ~cur_bank;
      wr_addr = {jy, jx};
      wr_data = {na, nb};
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      bank0[wr_addr] <= wr_data;
    end
    rd0 <= bank0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr1) begin
      bank1[wr_addr] <= wr_data;
    end
    rd1 <= bank1[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cur_bank  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_act)
              gsc_pkg::ACT_SWAP: cur_bank <= ~cur_bank;
              gsc_pkg::ACT_STEP: state <= ST_READ;
              default: ;
            endcase
          end
        end
        ST_READ:  state <= (rd_cnt == 4'd9) ? ST_MDA : ST_READ;
        ST_MDA:   state <= ST_MDB;
        ST_MDB:   state <= ST_MAB;
        ST_MAB:   state <= ST_MABB;
        ST_MABB:  state <= ST_MFA;
        ST_MFA:   state <= ST_MKB;
        ST_MKB:   state <= ST_DAM;
        ST_DAM:   state <= ST_DAC;
        ST_DAC:   state <= ST_DBC;
        ST_DBC:   state <= ST_SUM;
        ST_SUM:   state <= ST_OUT;
        ST_OUT: begin
          if (out_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      jx     <= q_x;
      jy     <= q_y;
      rd_cnt <= 4'd0;
    end
    if (state == ST_READ) begin
      rd_cnt <= rd_cnt + 4'd1;
      if (rd_cnt == 4'd0) begin
        la <= '0;
        lb <= '0;
      end else begin
        la <= la + term_a;
        lb <= lb + term_b;
      end
      if (prev == 4'd4) begin
        ca <= rd_cell[2*DW-1:DW];
        cb <= rd_cell[DW-1:0];
      end
    end
    if (state == ST_MDB) begin
      neg_a <= t_lap[20];
      ua    <= t_lap[20] ? t_neg[19:0] : t_lap[19:0];
    end
    if (state == ST_MAB) begin
      neg_b <= t_lap[20];
      ub    <= t_lap[20] ? t_neg[19:0] : t_lap[19:0];
    end
    if (state == ST_MFA) begin
      abb <= prod[33:15];
    end
    if (state == ST_MKB) begin
      fa <= $signed(prod[32:15]);
    end
    if (state == ST_DAM) begin
      kb <= prod[33:15];
    end
    if (state == ST_DAC) begin
      da <= neg_a ? -$signed({1'b0, q_a_fix}) : $signed({1'b0, q_a_fix});
    end
    if (state == ST_DBC) begin
      db <= neg_b ? -$signed({1'b0, q_b_fix}) : $signed({1'b0, q_b_fix});
    end
    if (state == ST_SUM) begin
      na <= na_c;
      nb <= nb_c;
    end
    if (out_fire) begin
      new_a      <= na;
      new_b      <= nb;
      gray_level <= gray;
    end
  end

endmodule

`default_nettype wire

// ----- src/gray_scott_cell_update.sv -----
// Top level of the Gray-Scott cell engine: configuration registers, front end,
// queue and back end. Depends on gsc_pkg, gsc_front, gsc_queue, gsc_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_ready  | action, x_pos, y_pos, conc_a, conc_b
//  out     | out_valid / out_ready| new_a, new_b, gray_level
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write or swap is handled in the idle state of the back end; a compute first
// makes the nine neighbour reads through the one registered read port of the
// bank, then passes through the shared multiplier, then sum and write-back.
// After reset every cell of both banks (grid sizes rounded up to powers of two)
// is swept to a=1, b=0; in_ready stays low meanwhile.
// A two-beat queue lets the front take beats while the back end is busy.
`timescale 1ns / 1ps
`default_nettype none

module gray_scott_cell_update #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 action,
  input  wire logic [7:0]                 x_pos,
  input  wire logic [7:0]                 y_pos,
  input  wire logic [gsc_pkg::DATA_W-1:0] conc_a,
  input  wire logic [gsc_pkg::DATA_W-1:0] conc_b,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [gsc_pkg::DATA_W-1:0]      new_a,
  output logic [gsc_pkg::DATA_W-1:0]      new_b,
  output logic [7:0]                      gray_level,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [gsc_pkg::DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int QW = 2 + YW + XW + 2 * gsc_pkg::DATA_W;

  gsc_pkg::cfg_t cfg;
  logic          clearing;
  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_a <= gsc_pkg::RST_DIFF_A;
      cfg.diff_b <= gsc_pkg::RST_DIFF_B;
      cfg.feed   <= gsc_pkg::RST_FEED;
      cfg.kill   <= gsc_pkg::RST_KILL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gsc_pkg::CFG_DIFF_A: cfg.diff_a <= cfg_data;
        gsc_pkg::CFG_DIFF_B: cfg.diff_b <= cfg_data;
        gsc_pkg::CFG_FEED:   cfg.feed   <= cfg_data;
        gsc_pkg::CFG_KILL:   cfg.kill   <= cfg_data;
        default: ;
      endcase
    end
  end

  gsc_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .enable   (~clearing),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .conc_a   (conc_a),
    .conc_b   (conc_b),
    .q_ready  (fq_ready),
    .q_valid  (fq_valid),
    .q_data   (fq_data)
  );

  gsc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  gsc_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_a      (new_a),
    .new_b      (new_b),
    .gray_level (gray_level),
    .clearing   (clearing)
  );

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during bank sweep");

  a_no_result_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result beat during bank sweep");

  a_result_in_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (new_a <= gsc_pkg::Q_ONE) && (new_b <= gsc_pkg::Q_ONE))
    else $error("result concentration above one");

  a_gray_dark : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (new_a <= new_b)) |-> (gray_level == 8'd0))
    else $error("gray level set although a does not exceed b");

endmodule

`default_nettype wire
